FILE: rtl/clrlf_pkg.sv
// Package for the clock rate line fit block.
// Holds default sizes, result status codes and the sequencer state type.
// No dependencies.
package clrlf_pkg;

	localparam int MAX_POINTS_DEF    = 64;
	localparam int DELTA_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 32;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FEW      = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_ZERO_DEN = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PT,
		S_CROSS,
		S_SQ,
		S_FIT,
		S_NUM1,
		S_NUM2,
		S_DEN1,
		S_DEN2,
		S_DIV1,
		S_RND,
		S_OFFM,
		S_DIV2,
		S_OFFP
	} state_t;

endpackage

FILE: rtl/clock_rate_line_fit_top.sv
// Least-squares fit of real time against a tick counter, one shared
// 32x32 multiply-accumulate and one 128-bit restoring divider step.
// Depends on clrlf_pkg.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------------
//  request   | start, busy              | real_time_us, tick_count, last_point,
//            |                          | clear_sums
//  result    | done (one-cycle strobe)  | slope_q, offset_us, points_used, status,
//            |                          | saturated
//  config    | cfg_valid, cfg_ready     | cfg_data (tick_shift)
//
// A point keeps busy high through one delta step, two products of ten 32x32
// partial products each through the single multiplier and one fit check. An
// origin or dropped point goes from the delta step to the fit check. A fit adds
// six products, 128+FRACTION_BITS divider steps for the slope, one rounding
// step and 128 steps for the offset; a zero or negative denominator ends it
// after four products. done follows a last point in the first idle cycle.
// Reset clears origin, sums, count, flags and tick_shift; no clearing pass.
// done is high for exactly one cycle; the receiver cannot stall it.
module clock_rate_line_fit_top #(
	parameter int MAX_POINTS    = clrlf_pkg::MAX_POINTS_DEF,
	parameter int DELTA_BITS    = clrlf_pkg::DELTA_BITS_DEF,
	parameter int FRACTION_BITS = clrlf_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [63:0]        real_time_us,
	input  logic [63:0]        tick_count,
	input  logic               last_point,
	input  logic               clear_sums,
	output logic               done,
	output logic signed [63:0] slope_q,
	output logic signed [63:0] offset_us,
	output logic [6:0]         points_used,
	output logic [1:0]         status,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);

	localparam int CW        = $clog2(MAX_POINTS + 1);
	localparam int DW        = DELTA_BITS;
	localparam int F         = FRACTION_BITS;
	localparam int DIV1_LAST = 128 + F - 1;
	localparam int DCW       = $clog2(128 + F);
	localparam logic signed [63:0] D_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam logic signed [63:0] D_MIN = -(64'sd1 <<< (DW - 1));
	localparam logic [127:0] HALF = 128'd1 << (F - 1);

	clrlf_pkg::state_t state_q, state_d;

	logic [4:0]    shift_q;
	logic [63:0]   origin_time_q, origin_ticks_q, in_time_q, in_ticks_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [63:0]   sum_time_q, sum_ticks_q;
	logic [127:0]  sum_cross_q, sum_sq_q;
	logic          clip_q, over_q;
	logic [DW-1:0] dk_q;
	logic [127:0]  acc_q, opa_q, opb_q;
	logic          sub_q;
	logic [1:0]    mi_q, mj_q;
	logic [127:0]  num_q, den_q, rem_q, quo_q;
	logic          ovf_q, neg_q;
	logic [DCW-1:0] dcnt_q;
	logic [63:0]   slope_val_q;
	logic          done_q;
	logic [63:0]   out_slope_q, out_off_q;
	logic [6:0]    out_pts_q;
	logic [1:0]    out_st_q;
	logic          out_sat_q;

	// multiply-accumulate step
	logic [31:0]  a_w, b_w;
	logic [63:0]  prod;
	logic [2:0]   wsum;
	logic [127:0] shifted, mac_res;
	logic         mac_last;

	assign a_w      = opa_q[{mi_q, 5'b0} +: 32];
	assign b_w      = opb_q[{mj_q, 5'b0} +: 32];
	assign prod     = {32'b0, a_w} * {32'b0, b_w};
	assign wsum     = {1'b0, mi_q} + {1'b0, mj_q};
	assign shifted  = {64'b0, prod} << {wsum[1:0], 5'b0};
	assign mac_res  = sub_q ? acc_q - shifted : acc_q + shifted;
	assign mac_last = (mi_q == 2'd3);

	// divider step
	logic [127:0] rsh, rem_d, quo_d;
	logic         ge;

	assign rsh   = {rem_q[126:0], num_q[127]};
	assign ge    = rsh >= den_q;
	assign rem_d = ge ? rsh - den_q : rsh;
	assign quo_d = {quo_q[126:0], ge};

	// point deltas
	logic signed [63:0] sdt, sdk;
	logic [DW-1:0]      dt_c, dk_c;
	logic               clip_t, clip_k;

	always_comb begin
		sdt    = $signed(in_time_q - origin_time_q);
		sdk    = $signed(in_ticks_q - origin_ticks_q) >>> shift_q;
		clip_t = (sdt > D_MAX) || (sdt < D_MIN);
		clip_k = (sdk > D_MAX) || (sdk < D_MIN);
		dt_c   = sdt > D_MAX ? D_MAX[DW-1:0] : (sdt < D_MIN ? D_MIN[DW-1:0] : sdt[DW-1:0]);
		dk_c   = sdk > D_MAX ? D_MAX[DW-1:0] : (sdk < D_MIN ? D_MIN[DW-1:0] : sdk[DW-1:0]);
	end

	// slope rounding and saturation
	logic [127:0] q_rnd;
	logic         sat_c;
	logic [63:0]  mag_c, slope_c;

	always_comb begin
		q_rnd   = ({rem_q, 1'b0} >= {1'b0, den_q}) ? quo_q + 128'd1 : quo_q;
		sat_c   = ovf_q || (q_rnd[127:64] != 64'd0) || q_rnd[63];
		mag_c   = sat_c ? 64'h7FFF_FFFF_FFFF_FFFF : q_rnd[63:0];
		slope_c = neg_q ? 64'd0 - mag_c : mag_c;
	end

	logic [127:0] a_quo;
	logic [63:0]  slope_mag, ot_s;
	logic [CW+6:0] pts_ext;

	assign a_quo     = neg_q ? 128'd0 - quo_d : quo_d;
	assign slope_mag = slope_val_q[63] ? 64'd0 - slope_val_q : slope_val_q;
	assign ot_s      = origin_ticks_q >> shift_q;
	assign pts_ext   = {7'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clrlf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clrlf_pkg::S_IDLE: begin
				if (start) state_d = clrlf_pkg::S_PT;
			end
			clrlf_pkg::S_PT: begin
				if (count_q == CW'(MAX_POINTS) || count_q == '0) state_d = clrlf_pkg::S_FIT;
				else state_d = clrlf_pkg::S_CROSS;
			end
			clrlf_pkg::S_CROSS: begin
				if (mac_last) state_d = clrlf_pkg::S_SQ;
			end
			clrlf_pkg::S_SQ: begin
				if (mac_last) state_d = clrlf_pkg::S_FIT;
			end
			clrlf_pkg::S_FIT: begin
				if (!last_q || over_q || count_q < CW'(2)) state_d = clrlf_pkg::S_IDLE;
				else state_d = clrlf_pkg::S_NUM1;
			end
			clrlf_pkg::S_NUM1: begin
				if (mac_last) state_d = clrlf_pkg::S_NUM2;
			end
			clrlf_pkg::S_NUM2: begin
				if (mac_last) state_d = clrlf_pkg::S_DEN1;
			end
			clrlf_pkg::S_DEN1: begin
				if (mac_last) state_d = clrlf_pkg::S_DEN2;
			end
			clrlf_pkg::S_DEN2: begin
				if (mac_last) begin
					if (mac_res[127] || mac_res == 128'd0) state_d = clrlf_pkg::S_IDLE;
					else state_d = clrlf_pkg::S_DIV1;
				end
			end
			clrlf_pkg::S_DIV1: begin
				if (dcnt_q == DCW'(DIV1_LAST)) state_d = clrlf_pkg::S_RND;
			end
			clrlf_pkg::S_RND: state_d = clrlf_pkg::S_OFFM;
			clrlf_pkg::S_OFFM: begin
				if (mac_last) state_d = clrlf_pkg::S_DIV2;
			end
			clrlf_pkg::S_DIV2: begin
				if (dcnt_q == DCW'(127)) state_d = clrlf_pkg::S_OFFP;
			end
			clrlf_pkg::S_OFFP: begin
				if (mac_last) state_d = clrlf_pkg::S_IDLE;
			end
			default: state_d = clrlf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q        <= '0;
			origin_time_q  <= '0;
			origin_ticks_q <= '0;
			in_time_q      <= '0;
			in_ticks_q     <= '0;
			last_q         <= 1'b0;
			count_q        <= '0;
			sum_time_q     <= '0;
			sum_ticks_q    <= '0;
			sum_cross_q    <= '0;
			sum_sq_q       <= '0;
			clip_q         <= 1'b0;
			over_q         <= 1'b0;
			dk_q           <= '0;
			acc_q          <= '0;
			opa_q          <= '0;
			opb_q          <= '0;
			sub_q          <= 1'b0;
			mi_q           <= '0;
			mj_q           <= '0;
			num_q          <= '0;
			den_q          <= '0;
			rem_q          <= '0;
			quo_q          <= '0;
			ovf_q          <= 1'b0;
			neg_q          <= 1'b0;
			dcnt_q         <= '0;
			slope_val_q    <= '0;
			done_q         <= 1'b0;
			out_slope_q    <= '0;
			out_off_q      <= '0;
			out_pts_q      <= '0;
			out_st_q       <= clrlf_pkg::ST_OK;
			out_sat_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) shift_q <= cfg_data;

			// shared MAC sequencing
			if (state_q == clrlf_pkg::S_CROSS || state_q == clrlf_pkg::S_SQ ||
			    state_q == clrlf_pkg::S_NUM1 || state_q == clrlf_pkg::S_NUM2 ||
			    state_q == clrlf_pkg::S_DEN1 || state_q == clrlf_pkg::S_DEN2 ||
			    state_q == clrlf_pkg::S_OFFM || state_q == clrlf_pkg::S_OFFP) begin
				acc_q <= mac_res;
				if (mac_last) begin
					mi_q <= '0;
					mj_q <= '0;
				end else if (wsum == 3'd3) begin
					mi_q <= mi_q + 2'd1;
					mj_q <= '0;
				end else begin
					mj_q <= mj_q + 2'd1;
				end
			end

			// shared divider step
			if (state_q == clrlf_pkg::S_DIV1 || state_q == clrlf_pkg::S_DIV2) begin
				num_q  <= {num_q[126:0], 1'b0};
				rem_q  <= rem_d;
				quo_q  <= quo_d;
				ovf_q  <= ovf_q | quo_q[127];
				dcnt_q <= dcnt_q + DCW'(1);
			end

			case (state_q)
				clrlf_pkg::S_IDLE: begin
					if (start) begin
						in_time_q  <= real_time_us;
						in_ticks_q <= tick_count;
						last_q     <= last_point;
						if (clear_sums) begin
							origin_time_q  <= '0;
							origin_ticks_q <= '0;
							count_q        <= '0;
							sum_time_q     <= '0;
							sum_ticks_q    <= '0;
							sum_cross_q    <= '0;
							sum_sq_q       <= '0;
							clip_q         <= 1'b0;
							over_q         <= 1'b0;
						end
					end
				end
				clrlf_pkg::S_PT: begin
					if (count_q == CW'(MAX_POINTS)) begin
						over_q <= 1'b1;
					end else if (count_q == '0) begin
						origin_time_q  <= in_time_q;
						origin_ticks_q <= in_ticks_q;
						count_q        <= CW'(1);
					end else begin
						clip_q      <= clip_q | clip_t | clip_k;
						dk_q        <= dk_c;
						sum_time_q  <= sum_time_q + {{(64-DW){dt_c[DW-1]}}, dt_c};
						sum_ticks_q <= sum_ticks_q + {{(64-DW){dk_c[DW-1]}}, dk_c};
						acc_q       <= sum_cross_q;
						opa_q       <= {{(128-DW){dt_c[DW-1]}}, dt_c};
						opb_q       <= {{(128-DW){dk_c[DW-1]}}, dk_c};
						sub_q       <= 1'b0;
					end
				end
				clrlf_pkg::S_CROSS: begin
					if (mac_last) begin
						sum_cross_q <= mac_res;
						acc_q       <= sum_sq_q;
						opa_q       <= {{(128-DW){dk_q[DW-1]}}, dk_q};
						opb_q       <= {{(128-DW){dk_q[DW-1]}}, dk_q};
					end
				end
				clrlf_pkg::S_SQ: begin
					if (mac_last) begin
						sum_sq_q <= mac_res;
						count_q  <= count_q + CW'(1);
					end
				end
				clrlf_pkg::S_FIT: begin
					out_slope_q <= '0;
					out_off_q   <= '0;
					out_pts_q   <= pts_ext[6:0];
					out_sat_q   <= clip_q;
					if (last_q) begin
						if (over_q) begin
							out_st_q <= clrlf_pkg::ST_OVERFLOW;
							done_q   <= 1'b1;
						end else if (count_q < CW'(2)) begin
							out_st_q <= clrlf_pkg::ST_FEW;
							done_q   <= 1'b1;
						end else begin
							acc_q <= '0;
							opa_q <= sum_cross_q;
							opb_q <= {{(128-CW){1'b0}}, count_q};
							sub_q <= 1'b0;
						end
					end
				end
				clrlf_pkg::S_NUM1: begin
					if (mac_last) begin
						opa_q <= {{64{sum_time_q[63]}}, sum_time_q};
						opb_q <= {{64{sum_ticks_q[63]}}, sum_ticks_q};
						sub_q <= 1'b1;
					end
				end
				clrlf_pkg::S_NUM2: begin
					if (mac_last) begin
						neg_q <= mac_res[127];
						num_q <= mac_res[127] ? 128'd0 - mac_res : mac_res;
						acc_q <= '0;
						opa_q <= sum_sq_q;
						opb_q <= {{(128-CW){1'b0}}, count_q};
						sub_q <= 1'b0;
					end
				end
				clrlf_pkg::S_DEN1: begin
					if (mac_last) begin
						opa_q <= {{64{sum_ticks_q[63]}}, sum_ticks_q};
						opb_q <= {{64{sum_ticks_q[63]}}, sum_ticks_q};
						sub_q <= 1'b1;
					end
				end
				clrlf_pkg::S_DEN2: begin
					if (mac_last) begin
						if (mac_res[127] || mac_res == 128'd0) begin
							out_st_q <= clrlf_pkg::ST_ZERO_DEN;
							done_q   <= 1'b1;
						end else begin
							den_q  <= mac_res;
							rem_q  <= '0;
							quo_q  <= '0;
							ovf_q  <= 1'b0;
							dcnt_q <= '0;
						end
					end
				end
				clrlf_pkg::S_RND: begin
					slope_val_q <= slope_c;
					acc_q       <= {{64{sum_time_q[63]}}, sum_time_q} << F;
					opa_q       <= {{64{slope_c[63]}}, slope_c};
					opb_q       <= {{64{sum_ticks_q[63]}}, sum_ticks_q};
					sub_q       <= 1'b1;
				end
				clrlf_pkg::S_OFFM: begin
					if (mac_last) begin
						neg_q  <= mac_res[127];
						num_q  <= mac_res[127] ? 128'd0 - mac_res : mac_res;
						den_q  <= {{(128-CW){1'b0}}, count_q};
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= '0;
					end
				end
				clrlf_pkg::S_DIV2: begin
					if (dcnt_q == DCW'(127)) begin
						acc_q <= ({64'b0, origin_time_q} << F) + a_quo + HALF;
						opa_q <= {64'b0, slope_mag};
						opb_q <= {64'b0, ot_s};
						sub_q <= !slope_val_q[63];
					end
				end
				clrlf_pkg::S_OFFP: begin
					if (mac_last) begin
						out_slope_q <= slope_val_q;
						out_off_q   <= mac_res[F+63:F];
						out_st_q    <= clrlf_pkg::ST_OK;
						done_q      <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy        = (state_q != clrlf_pkg::S_IDLE);
	assign cfg_ready   = !busy;
	assign done        = done_q;
	assign slope_q     = $signed(out_slope_q);
	assign offset_us   = $signed(out_off_q);
	assign points_used = out_pts_q;
	assign status      = out_st_q;
	assign saturated   = out_sat_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == clrlf_pkg::S_IDLE)
		else $error("result strobe outside idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store size");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == clrlf_pkg::S_DIV1 |-> den_q != 128'd0 && !den_q[127])
		else $error("division by zero or negative denominator");

endmodule
